// ===== hdl/pes_pkg.sv =====
// Shared widths and constants for the product-except-self block.
package pes_pkg;

  localparam int DATA_W = 32;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t WORD_ONE = word_t'(1);

endpackage

// ===== hdl/product_except_self_top.sv =====
// Top level of the product-except-self block: loader, shared multiplier and sequencer.
//
// Usage: each element is one request, taken at a clock edge where start is high and
// busy is low; loading takes one element per cycle. The element with last set, or the
// one that fills MAX_LEN entries, closes the vector. The block then stays busy for a
// forward prefix pass of a read and a multiply step per element, a backward suffix
// pass of a read, an answer and a suffix step per element, and a readout of one step
// per element. Each result shows in the cycle after its readout step, and the final
// one lands on the first cycle with busy low. One 32x32 multiplier is shared by both
// passes, and each element and answer memory has a single read port. Results appear
// in index order, one per cycle with strobe high, final_res marking the last; the
// receiver cannot stall them. Products wrap modulo 2^32; a single element yields 1.
module product_except_self_top #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               strobe,
  output logic signed [31:0] product,
  output logic               final_res
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_LEN - 1);

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_FWD_RD  = 3'd1;
  localparam logic [2:0] S_FWD_MUL = 3'd2;
  localparam logic [2:0] S_BWD_RD  = 3'd3;
  localparam logic [2:0] S_BWD_ANS = 3'd4;
  localparam logic [2:0] S_BWD_SUF = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   last_idx;
  pes_pkg::word_t     acc;

  logic               accept;
  logic               closing;

  logic               elem_we;
  logic [IDX_W-1:0]   elem_waddr;
  logic               elem_re;
  pes_pkg::word_t     elem_rd;

  logic               ans_we;
  pes_pkg::word_t     ans_wdata;
  logic               ans_re;
  pes_pkg::word_t     ans_rd;

  pes_pkg::word_t     mul_b;
  pes_pkg::word_t     mul_lo;

  assign busy    = (state != S_LOAD);
  assign accept  = start && !busy;
  assign closing = last || (cnt == CNT_TOP);

  // shared multiplier: accumulator times element or stored answer, low word kept
  assign mul_b  = (state == S_BWD_ANS) ? ans_rd : elem_rd;
  assign mul_lo = acc * mul_b;

  // memory port control
  assign elem_we    = accept;
  assign elem_waddr = cnt[IDX_W-1:0];
  assign elem_re    = (state == S_FWD_RD) || (state == S_BWD_RD);
  assign ans_we     = (state == S_FWD_RD) || (state == S_BWD_ANS);
  assign ans_wdata  = (state == S_FWD_RD) ? acc : mul_lo;
  assign ans_re     = (state == S_BWD_RD) || (state == S_EMIT);

  pes_ram #(
    .WIDTH (pes_pkg::DATA_W),
    .DEPTH (MAX_LEN)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (pes_pkg::word_t'(value)),
    .re    (elem_re),
    .raddr (idx),
    .rdata (elem_rd)
  );

  pes_ram #(
    .WIDTH (pes_pkg::DATA_W),
    .DEPTH (MAX_LEN)
  ) u_ans_ram (
    .clk   (clk),
    .we    (ans_we),
    .waddr (idx),
    .wdata (ans_wdata),
    .re    (ans_re),
    .raddr (idx),
    .rdata (ans_rd)
  );

  assign product = ans_rd;

  // sequencer: load, forward prefix pass, backward suffix pass, readout
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      idx       <= '0;
      strobe    <= 1'b0;
      final_res <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      final_res <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (closing) begin
              last_idx <= cnt[IDX_W-1:0];
              cnt      <= '0;
              idx      <= '0;
              acc      <= pes_pkg::WORD_ONE;
              state    <= S_FWD_RD;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_FWD_RD: begin
          state <= S_FWD_MUL;
        end
        S_FWD_MUL: begin
          if (idx == last_idx) begin
            acc   <= pes_pkg::WORD_ONE;
            state <= S_BWD_RD;
          end else begin
            acc   <= mul_lo;
            idx   <= idx + 1'b1;
            state <= S_FWD_RD;
          end
        end
        S_BWD_RD: begin
          state <= S_BWD_ANS;
        end
        S_BWD_ANS: begin
          state <= S_BWD_SUF;
        end
        S_BWD_SUF: begin
          acc <= mul_lo;
          if (idx == '0) begin
            state <= S_EMIT;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_BWD_RD;
          end
        end
        S_EMIT: begin
          strobe    <= 1'b1;
          final_res <= (idx == last_idx);
          if (idx == last_idx) begin
            state <= S_LOAD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== hdl/pes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  clk,
  we,
  waddr,
  wdata,
  re,
  raddr,
  rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             we;
  input  logic [AW-1:0]    waddr;
  input  logic [WIDTH-1:0] wdata;
  input  logic             re;
  input  logic [AW-1:0]    raddr;
  output logic [WIDTH-1:0] rdata;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read; hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pes_check.sv =====
// Port-level checker for the product-except-self block, bound to the top level.
module pes_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               last,
  input logic               strobe,
  input logic               final_res
);

  // an accepted request is never followed directly by a result strobe
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("result strobe right after an accepted request");

  // a request with last set starts the computation
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("block not busy after the closing element");

  // readout runs without gaps until the final result
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !final_res) |=> strobe)
    else $error("gap in result stream before the final result");

  // leaving busy coincides with the final result
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (strobe && final_res))
    else $error("busy dropped without the final result");

  // final marker only travels with a result
  assert property (@(posedge clk) disable iff (rst)
    final_res |-> strobe)
    else $error("final_res without strobe");

endmodule

bind product_except_self_top pes_check u_pes_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .last      (last),
  .strobe    (strobe),
  .final_res (final_res)
);

// ===== tb/product_except_self_checker.sv =====
// Predicts and checks the product-except-self results seen at the block's ports.
`timescale 1ns / 100ps

module product_except_self_checker #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] value,
  input  logic               last,
  input  logic               strobe,
  input  logic signed [31:0] product,
  input  logic               final_res,
  output int                 fails,
  output int                 pending,
  output int                 results_seen,
  output int                 vectors_seen
);

  typedef struct packed {
    pes_pkg::word_t product;
    logic           final_res;
  } answer_t;

  pes_pkg::word_t loaded_elems [MAX_LEN];
  int             loaded_count;
  answer_t        expected_products [$];

  // Close the loaded vector: push one expected answer per position, brute force.
  task automatic predict_products();
    pes_pkg::word_t acc;
    for (int i = 0; i < loaded_count; i++) begin
      acc = pes_pkg::WORD_ONE;
      for (int j = 0; j < loaded_count; j++) begin
        if (j != i) begin
          acc = acc * loaded_elems[j];
        end
      end
      expected_products.push_back('{product: acc, final_res: (i == loaded_count - 1)});
    end
    loaded_count = 0;
    vectors_seen++;
  endtask

  // Count a failure; print details only for the first few.
  task automatic report_mismatch(input string what, input answer_t want);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s at result %0d: expected product %0d final_res %0b, got %0d final_res %0b",
               $realtime, what, results_seen, $signed(want.product), want.final_res,
               product, final_res);
    end
  endtask

  // Compare strobed results first, then record any request taken on this edge.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      loaded_count = 0;
      expected_products.delete();
      fails        = 0;
      results_seen = 0;
      vectors_seen = 0;
    end else begin
      if (strobe) begin
        if (expected_products.size() == 0) begin
          report_mismatch("unexpected result", '0);
        end else begin
          want = expected_products.pop_front();
          if (pes_pkg::word_t'(product) !== want.product || final_res !== want.final_res) begin
            report_mismatch("mismatch", want);
          end
        end
        results_seen++;
      end
      if (start && !busy) begin
        loaded_elems[loaded_count] = pes_pkg::word_t'(value);
        loaded_count++;
        if (last || loaded_count == MAX_LEN) begin
          predict_products();
        end
      end
    end
    pending = expected_products.size();
  end

endmodule

// ===== tb/product_except_self_top_test.sv =====
// Stimulus and verdict for the product-except-self block.
`timescale 1ns / 100ps

module product_except_self_top_test;

  localparam int VEC_MAX   = 64;
  localparam int NUM_ITEMS = 320;
  localparam int NUM_DIRECTED = 20;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] value = '0;
  logic               last  = 1'b0;
  logic               busy;
  logic               strobe;
  logic signed [31:0] product;
  logic               final_res;

  int fails;
  int pending;
  int results_seen;
  int vectors_seen;
  int requests_sent = 0;
  bit allow_idle    = 1'b1;

  // Hand-picked vectors: single element, extremes, zeros, sign flips, wraparound.
  pes_pkg::word_t directed_vals [NUM_DIRECTED] = '{
    32'h8000_0000,
    32'h7fff_ffff, 32'h8000_0000,
    32'h0000_0000, 32'h0000_0005, 32'hffff_fffd,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0009,
    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
    32'h0000_0001, 32'h0001_0000, 32'h0001_0000, 32'h0000_0003
  };
  bit directed_last [NUM_DIRECTED] = '{
    1,
    0, 1,
    0, 0, 1,
    0, 0, 1,
    0, 0, 0, 1,
    0, 0, 1,
    0, 0, 0, 1
  };

  always #5 clk = ~clk;

  product_except_self_top #(.MAX_LEN(VEC_MAX)) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .last      (last),
    .strobe    (strobe),
    .product   (product),
    .final_res (final_res)
  );

  product_except_self_checker #(.MAX_LEN(VEC_MAX)) u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .last         (last),
    .strobe       (strobe),
    .product      (product),
    .final_res    (final_res),
    .fails        (fails),
    .pending      (pending),
    .results_seen (results_seen),
    .vectors_seen (vectors_seen)
  );

  // Present one element request and hold it until taken; maybe idle afterwards.
  task automatic send_request(input pes_pkg::word_t v, input logic l);
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    last  <= l;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  endtask

  // Mix extremes, unit values and small signed numbers with fully random words.
  function automatic pes_pkg::word_t pick_value(input bit keep_nonzero);
    if (keep_nonzero) begin
      return pes_pkg::word_t'($urandom) | pes_pkg::WORD_ONE;
    end
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return pes_pkg::WORD_ONE;
      4:       return '1;
      5, 6:    return pes_pkg::word_t'($urandom);
      default: return pes_pkg::word_t'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  initial begin
    int  vec_len;
    int  rand_vecs;
    int  guard;
    bit  close_by_last;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Run the directed vectors.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(directed_vals[i], directed_last[i]);
    end

    // Random vectors; the first two fill the store, without and with last on the final slot.
    rand_vecs = 0;
    while (requests_sent < NUM_ITEMS) begin
      if (requests_sent > NUM_ITEMS - 40) begin
        allow_idle = 1'b0;
      end
      if (rand_vecs < 2 ||
          (requests_sent + VEC_MAX <= NUM_ITEMS && $urandom_range(0, 19) == 0)) begin
        vec_len       = VEC_MAX;
        close_by_last = (rand_vecs < 2) ? 1'(rand_vecs) : 1'($urandom_range(0, 1));
      end else begin
        vec_len       = $urandom_range(1, 8);
        close_by_last = 1'b1;
      end
      for (int i = 0; i < vec_len; i++) begin
        send_request(pick_value(vec_len == VEC_MAX), close_by_last && (i == vec_len - 1));
      end
      rand_vecs++;
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding results, then watch for strays.
    guard = 0;
    while (pending != 0 && guard < 20 * VEC_MAX) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);

    $display("Sent %0d element requests in %0d vectors,", requests_sent, vectors_seen);
    $display("incl. single-element and full-length ones.");
    $display("Checked %0d results: %0d failures, %0d still outstanding.",
             results_seen, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Abort a hung run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
